>>> sv/acmm_pkg.sv
package acmm_pkg;

    localparam int NCH      = 8;
    localparam int CH_W     = $clog2(NCH);
    localparam int CNT_W    = $clog2(NCH + 1);
    localparam int FRAC     = 14;
    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 52;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_REG_W  = 4;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 32'h7fffffff;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 32'h80000000;

    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 4'd1;

    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // sample token traveling down the row of cells
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     pos;
    } tok_t;

    // broadcast control for every cell
    typedef struct packed {
        logic              clear;
        logic              load;
        logic              shift;
        logic              wr_en;
        logic [CH_W-1:0]   wr_row;
        logic [CH_W-1:0]   wr_col;
        logic [COEF_W-1:0] wr_value;
    } cell_ctl_t;

    // register value 0 acts as 1, above NCH acts as NCH
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_REG_W-1:0] r);
        logic [CNT_W-1:0] c;
        if (r == '0)
            c = CNT_W'(1);
        else if (int'(r) > NCH)
            c = CNT_W'(NCH);
        else
            c = CNT_W'(r);
        return c;
    endfunction

    // truncate toward zero by FRAC bits, then clip to signed 32 bits
    function automatic logic [SAMPLE_W-1:0] scale_clip(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0]        mag;
        logic [ACC_W-1:0]        q_mag;
        logic signed [ACC_W-1:0] q;
        logic [SAMPLE_W-1:0]     r;
        mag   = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
        q_mag = mag >> FRAC;
        q     = acc[ACC_W-1] ? $signed(-q_mag) : $signed(q_mag);
        if (q > $signed(ACC_W'(SAT_MAX)))
            r = SAT_MAX;
        else if (q < $signed({{(ACC_W-SAMPLE_W){1'b1}}, SAT_MIN}))
            r = SAT_MIN;
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

>>> sv/audio_channel_matrix_mixer_core.sv
// a coefficient item leaves the block ready; a sample item keeps the block busy while the
// token walks the 8 cells and the last cell multiplies and accumulates
// the frame's last sample adds a load step and then one result per cycle while the
// output is not stalled; a new item is taken only once the previous one is through
// reset: asynchronous active low, gains and accumulators zero, channel counts 2
module audio_channel_matrix_mixer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acmm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic signed [31:0]                sample,
    input  logic [2:0]                        coef_row,
    input  logic [2:0]                        coef_col,
    input  logic signed [15:0]                coef_value,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                out_sample,
    output logic [2:0]                        out_channel,
    output logic                              frame_last
);
    import acmm_pkg::*;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    // MAC count at which the last cell accumulates
    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(NCH);

    state_t                 state_reg, state_next;
    logic [CNT_REG_W-1:0]   in_ch_reg, in_ch_next;
    logic [CNT_REG_W-1:0]   out_ch_reg, out_ch_next;
    logic [CH_W-1:0]        fp_reg, fp_next;
    logic                   last_reg, last_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CH_W-1:0]        idx_reg, idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]    out_sample_reg;
    logic [CH_W-1:0]        out_channel_reg;
    logic                   frame_last_reg;

    logic                   in_acc;
    logic                   cfg_acc;
    logic                   cfg_hit;
    logic                   coef_acc;
    logic                   smp_acc;
    logic [CNT_W-1:0]       nin;
    logic [CNT_W-1:0]       nout;
    logic [CH_W-1:0]        pos_eff;
    logic                   pos_last;
    logic [CH_W-1:0]        nout_m1;
    logic                   shift_en;

    cell_ctl_t              ctl;
    tok_t                   tok_chain [NCH+1];
    logic [SAMPLE_W-1:0]    res_chain [NCH+1];

    assign nin     = eff_count(in_ch_reg);
    assign nout    = eff_count(out_ch_reg);
    assign nout_m1 = CH_W'(nout - CNT_W'(1));

    // configuration is always taken; the user must only use the port while idle, the block does not enforce it
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_acc && (cfg_index == REG_IN_CHANNELS || cfg_index == REG_OUT_CHANNELS);

    // one item at a time: input taken only when the row of cells is quiet
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign coef_acc = in_acc && (req_type == REQ_COEF);
    assign smp_acc  = in_acc && (req_type == REQ_SAMPLE);

    // frame position clamped to the last channel of the current input channel count
    assign pos_eff  = (CNT_W'(fp_reg) >= nin) ? CH_W'(nin - CNT_W'(1)) : fp_reg;
    assign pos_last = (CNT_W'(CNT_W'(pos_eff) + CNT_W'(1)) >= nin);

    // output register drains one result per cycle when free or being taken
    assign shift_en = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);

    // broadcast control
    always_comb
    begin
        ctl.clear    = cfg_hit || coef_acc;
        ctl.load     = (state_reg == ST_LOAD);
        ctl.shift    = shift_en;
        ctl.wr_en    = coef_acc && (int'(coef_row) < NCH) && (int'(coef_col) < NCH);
        ctl.wr_row   = CH_W'(coef_row);
        ctl.wr_col   = CH_W'(coef_col);
        ctl.wr_value = coef_value;
    end

    // a sample enters the first cell of the row on acceptance
    assign tok_chain[0] = '{valid: smp_acc, sample: sample, pos: pos_eff};

    // nothing shifts in past the far end
    assign res_chain[NCH] = '0;

    for (genvar i = 0; i < NCH; i++)
    begin : g_cell
        acmm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .col_idx (CH_W'(i)),
            .ctl     (ctl),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .res_in  (res_chain[i+1]),
            .res_out (res_chain[i])
        );
    end

    // sequencer and frame bookkeeping
    always_comb
    begin
        state_next  = state_reg;
        in_ch_next  = in_ch_reg;
        out_ch_next = out_ch_reg;
        fp_next     = fp_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;

        // a write to either channel count register restarts the frame
        if (cfg_acc && cfg_index == REG_IN_CHANNELS)
        begin
            in_ch_next = cfg_data[CNT_REG_W-1:0];
            fp_next    = '0;
        end
        else if (cfg_acc && cfg_index == REG_OUT_CHANNELS)
        begin
            out_ch_next = cfg_data[CNT_REG_W-1:0];
            fp_next     = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (coef_acc)
                begin
                    fp_next = '0;
                end
                else if (smp_acc)
                begin
                    fp_next    = pos_last ? '0 : CH_W'(pos_eff + CH_W'(1));
                    last_next  = pos_last;
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == MAC_LAST)
                    state_next = last_reg ? ST_LOAD : ST_IDLE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_LOAD:
            begin
                idx_next   = '0;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (shift_en)
                begin
                    if (idx_reg == nout_m1)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + CH_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (shift_en)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ch_reg     <= CNT_REG_W'(2);
            out_ch_reg    <= CNT_REG_W'(2);
            fp_reg        <= '0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ch_reg     <= in_ch_next;
            out_ch_reg    <= out_ch_next;
            fp_reg        <= fp_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded from the head of the row
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            out_sample_reg  <= res_chain[0];
            out_channel_reg <= idx_reg;
            frame_last_reg  <= (idx_reg == nout_m1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign out_channel = 3'(out_channel_reg);
    assign frame_last  = frame_last_reg;

endmodule

>>> sv/acmm_cell.sv
module acmm_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [acmm_pkg::CH_W-1:0]       col_idx,
    input  acmm_pkg::cell_ctl_t             ctl,
    input  acmm_pkg::tok_t                  tok_in,
    output acmm_pkg::tok_t                  tok_out,
    input  logic [acmm_pkg::SAMPLE_W-1:0]   res_in,
    output logic [acmm_pkg::SAMPLE_W-1:0]   res_out
);
    import acmm_pkg::*;

    tok_t                     tok_reg;
    logic [COEF_W-1:0]        coef_reg [NCH];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SAMPLE_W-1:0]      res_reg;

    // one column of the gain matrix: this cell's output channel
    assign prod_next = $signed(tok_reg.sample) * $signed(coef_reg[tok_reg.pos]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= '0;
            prod_v_reg    <= 1'b0;
            acc_reg       <= '0;
            for (int r = 0; r < NCH; r++)
            begin
                coef_reg[r] <= '0;
            end
        end
        else
        begin
            tok_reg       <= tok_in;
            prod_v_reg    <= tok_reg.valid;
            if (ctl.wr_en && ctl.wr_col == col_idx)
            begin
                coef_reg[ctl.wr_row] <= ctl.wr_value;
            end
            if (ctl.clear || ctl.load)
                acc_reg <= '0;
            else if (prod_v_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        if (ctl.load)
            res_reg <= scale_clip(acc_reg);
        else if (ctl.shift)
            res_reg <= res_in;
    end

    assign tok_out = tok_reg;
    assign res_out = res_reg;

endmodule

>>> sv/acmm_checker.sv
module acmm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_sample,
    input logic [2:0]  out_channel,
    input logic        frame_last
);
    import acmm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample)
            && $stable(out_channel) && $stable(frame_last))
        else $error("result changed while stalled");

    // the block is ready again in the next cycle after a coefficient write
    a_coef_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_COEF |=> in_ready)
        else $error("busy after coefficient item");

    // a sample keeps the block busy
    a_smp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_SAMPLE |=> !in_ready)
        else $error("ready right after sample item");

    // while a frame is still being emitted no new item is taken
    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_last |-> !in_ready)
        else $error("input taken during frame output");

endmodule

bind audio_channel_matrix_mixer_core acmm_checker u_acmm_checker (.*);

>>> test/audio_channel_matrix_mixer_core_tb.sv
module audio_channel_matrix_mixer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import acmm_pkg::*;

    // cycles to let a sample item drain through the cell row before a register write
    localparam int DRAIN_CYCLES = 24;
    // cycles with no handshake on any channel before the run is declared hung
    localparam int HANG_LIMIT   = 2000;
    localparam int PHASES       = 8;
    localparam int PLAN_LEN     = 23;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = REQ_COEF;
    logic signed [31:0] sample = '0;
    logic [2:0]         coef_row = '0;
    logic [2:0]         coef_col = '0;
    logic signed [15:0] coef_value = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] out_sample;
    logic [2:0]         out_channel;
    logic               frame_last;

    audio_channel_matrix_mixer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .sample      (sample),
        .coef_row    (coef_row),
        .coef_col    (coef_col),
        .coef_value  (coef_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .out_channel (out_channel),
        .frame_last  (frame_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // one mixed output channel as the block should emit it
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  chan;
        logic        last;
    } mix_out_t;

    // directed stimulus row; want0/want1 hold hand-computed outputs for a
    // two-channel frame end when typed is set
    typedef struct packed {
        logic        kind;
        logic [31:0] smp;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] gain;
        logic        typed;
        logic [31:0] want0;
        logic [31:0] want1;
    } plan_row_t;

    // mixer state mirrored by the testbench
    logic signed [15:0] gains [NCH][NCH];
    longint             acc_sum [NCH];
    int unsigned        frame_pos;
    logic [3:0]         in_reg;
    logic [3:0]         out_reg;

    mix_out_t mix_q [$];

    int fail_count;
    int items_sent;
    int results_seen;
    int frames_mixed;
    int reg_writes;
    int idle_cycles;
    int stall_left;
    bit calm;

    // channel setting per phase, extremes first; the last two are drawn at random
    logic [3:0] in_set  [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd0, 4'd0};
    logic [3:0] out_set [PHASES] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd9, 4'd0, 4'd0};

    // reset config is two in, two out, all gains zero
    plan_row_t plan [PLAN_LEN] = '{
        // all gains zero after reset, extreme samples mix to zero
        '{REQ_SAMPLE, SAT_MAX,       3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, SAT_MIN,       3'd0, 3'd0, 16'h0000, 1'b1, 32'h0, 32'h0},
        // largest positive and negative gains
        '{REQ_COEF,   32'h0,         3'd0, 3'd0, 16'h7fff, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd0, 3'd1, 16'h8000, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd1, 3'd0, 16'h7fff, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd1, 3'd1, 16'h8000, 1'b0, 32'h0, 32'h0},
        // gain of an inactive channel, kept but unused
        '{REQ_COEF,   32'h0,         3'd7, 3'd7, 16'h1234, 1'b0, 32'h0, 32'h0},
        // both outputs saturate, one each way
        '{REQ_SAMPLE, SAT_MAX,       3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, SAT_MAX,       3'd0, 3'd0, 16'h0000, 1'b1, SAT_MAX, SAT_MIN},
        '{REQ_SAMPLE, SAT_MIN,       3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, SAT_MIN,       3'd0, 3'd0, 16'h0000, 1'b1, SAT_MIN, SAT_MAX},
        // tiny gain on out 0, unity gain on out 1
        '{REQ_COEF,   32'h0,         3'd0, 3'd0, 16'h0001, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd0, 3'd1, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd1, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd1, 3'd1, 16'h4000, 1'b0, 32'h0, 32'h0},
        // -16385 / 2^14 truncates toward zero to -1, not -2
        '{REQ_SAMPLE, 32'hffffbfff,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, 32'd3,         3'd0, 3'd0, 16'h0000, 1'b1, 32'hffffffff, 32'd3},
        // gain write in mid frame drops the partial frame
        '{REQ_SAMPLE, 32'h12345678,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_COEF,   32'h0,         3'd1, 3'd0, 16'h2000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, 32'h00004000,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, 32'hffff0000,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        // alternating bit patterns
        '{REQ_SAMPLE, 32'h55555555,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{REQ_SAMPLE, 32'haaaaaaaa,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0, 32'h0}
    };

    // register value 0 means one channel, anything above NCH means NCH
    function automatic int unsigned chan_count(input logic [3:0] r);
        int unsigned n;
        if (r == 4'd0)
            n = 1;
        else if (r > 4'(NCH))
            n = NCH;
        else
            n = r;
        return n;
    endfunction

    function automatic void drop_frame();
        foreach (acc_sum[o])
            acc_sum[o] = 0;
        frame_pos = 0;
    endfunction

    // exact sum scaled down by the gain fraction, toward zero, then clipped
    function automatic logic [31:0] clip_q14(input longint sum);
        longint      q;
        logic [31:0] r;
        q = sum / (longint'(1) << FRAC);
        if (q > 64'sd2147483647)
            r = SAT_MAX;
        else if (q < -64'sd2147483648)
            r = SAT_MIN;
        else
            r = q[31:0];
        return r;
    endfunction

    // advance the mirrored mixer by one accepted item, queue any outputs
    function automatic void mix_step(input logic kind, input logic [31:0] smp,
                                     input logic [2:0] row, input logic [2:0] col,
                                     input logic [15:0] gain, input logic typed,
                                     input logic [31:0] want0, input logic [31:0] want1);
        int unsigned nin;
        int unsigned nout;
        mix_out_t    r;
        nin  = chan_count(in_reg);
        nout = chan_count(out_reg);
        if (kind == REQ_COEF)
        begin
            gains[row][col] = gain;
            drop_frame();
        end
        else
        begin
            if (frame_pos >= nin)
                frame_pos = nin - 1;
            for (int o = 0; o < nout; o++)
                acc_sum[o] += longint'($signed(smp)) * longint'(gains[frame_pos][o]);
            if (frame_pos + 1 < nin)
                frame_pos++;
            else
            begin
                for (int o = 0; o < nout; o++)
                begin
                    // hand-computed values only ever cover a two-channel frame
                    if (typed)
                        r.value = (o == 0) ? want0 : want1;
                    else
                        r.value = clip_q14(acc_sum[o]);
                    r.chan = 3'(o);
                    r.last = (o + 1 == nout);
                    mix_q.push_back(r);
                end
                frames_mixed++;
                drop_frame();
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(input logic kind, input logic [31:0] smp,
                             input logic [2:0] row, input logic [2:0] col,
                             input logic [15:0] gain, input logic typed,
                             input logic [31:0] want0, input logic [31:0] want1);
        in_valid   <= 1'b1;
        req_type   <= kind;
        sample     <= smp;
        coef_row   <= row;
        coef_col   <= col;
        coef_value <= gain;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        mix_step(kind, smp, row, col, gain, typed, want0, want1);
    endtask

    // random gain, biased toward the full-scale and unity values
    task automatic send_rand_gain();
        logic [15:0] g;
        case ($urandom_range(0, 7))
            0: g = 16'h7fff;
            1: g = 16'h8000;
            2: g = 16'h4000;
            3: g = 16'hc000;
            default: g = 16'($urandom());
        endcase
        send_item(REQ_COEF, 32'($urandom()), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), g, 1'b0, 32'h0, 32'h0);
    endtask

    // sender gap after an item: mostly none, sometimes short, rarely long
    task automatic rest();
        int unsigned gap;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // block idle: nothing owed, and any non-final sample has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (mix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        if (idx == REG_IN_CHANNELS)
        begin
            in_reg = data[3:0];
            drop_frame();
        end
        else if (idx == REG_OUT_CHANNELS)
        begin
            out_reg = data[3:0];
            drop_frame();
        end
    endtask

    // result side: random back-pressure, compare in order, hang watchdog
    always @(posedge clk)
    begin
        mix_out_t want;
        if (calm)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 39))
                0: stall_left = $urandom_range(15, 40);
                1, 2, 3, 4, 5, 6: stall_left = $urandom_range(1, 3);
                default: stall_left = 0;
            endcase
            out_ready <= (stall_left == 0);
        end

        if (rst_n && out_valid && out_ready)
        begin
            if (mix_q.size() == 0)
            begin
                $display("%0t: result with none owed: expected nothing, got %h ch %0d last %0b",
                         $time, out_sample, out_channel, frame_last);
                fail_count++;
            end
            else
            begin
                want = mix_q.pop_front();
                check_field("out_sample", want.value, out_sample);
                check_field("out_channel", 32'(want.chan), 32'(out_channel));
                check_field("frame_last", 32'(want.last), 32'(frame_last));
                results_seen++;
            end
        end

        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
            (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results still owed",
                     $time, HANG_LIMIT, mix_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned nin;
        int unsigned n_samp;
        logic [31:0] smp;

        foreach (gains[r, c])
            gains[r][c] = '0;
        in_reg  = 4'd2;
        out_reg = 4'd2;
        drop_frame();
        in_set[6]  = 4'($urandom());
        in_set[7]  = 4'($urandom());
        out_set[6] = 4'($urandom());
        out_set[7] = 4'($urandom());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset channel counts
        foreach (plan[i])
        begin
            send_item(plan[i].kind, plan[i].smp, plan[i].row, plan[i].col, plan[i].gain,
                      plan[i].typed, plan[i].want0, plan[i].want1);
            rest();
        end

        // random part, one channel setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            calm = (ph % 3 == 2);
            // unused register index, must leave the frame alone
            write_reg(4'($urandom_range(2, 15)), $urandom());
            write_reg(REG_IN_CHANNELS, {28'($urandom()), in_set[ph]});
            write_reg(REG_OUT_CHANNELS, {28'($urandom()), out_set[ph]});
            cfg_valid <= 1'b0;

            if (ph == 0 || $urandom_range(0, 1) == 1)
                repeat ($urandom_range(2, 8))
                begin
                    send_rand_gain();
                    rest();
                end

            // mostly whole frames; an odd gain write breaks one now and then
            nin    = chan_count(in_reg);
            n_samp = (nin > 4) ? 2 * nin : 3 * nin + $urandom_range(0, 3);
            repeat (n_samp)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_rand_gain();
                else
                begin
                    case ($urandom_range(0, 7))
                        0: smp = SAT_MAX;
                        1: smp = SAT_MIN;
                        2, 3, 4: smp = 32'(int'($urandom_range(0, 2097152)) - 1048576);
                        default: smp = $urandom();
                    endcase
                    send_item(REQ_SAMPLE, smp, 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)), 16'($urandom()), 1'b0, 32'h0, 32'h0);
                end
                rest();
            end
        end

        calm = 1'b0;
        settle();

        $display("mixed %0d frames from %0d input items, %0d output samples checked",
                 frames_mixed, items_sent, results_seen);
        $display("%0d register writes over %0d channel settings, zero and over-range included",
                 reg_writes, PHASES);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/acmm_pkg.sv
sv/acmm_cell.sv
sv/audio_channel_matrix_mixer_core.sv
sv/acmm_checker.sv
test/audio_channel_matrix_mixer_core_tb.sv
